// ----- sv/lis_pkg.sv -----
// Package for the longest increasing subsequence tracker.
// Holds the beat types of both channels and the sign-bias constant.
// No dependencies.
`default_nettype none

package lis_pkg;

	localparam int unsigned VALUE_W = 32;
	localparam int unsigned LEN_OUT_W = 11;

	localparam logic [VALUE_W-1:0] SIGN_BIAS = 32'h8000_0000;

	typedef struct packed {
		logic signed [VALUE_W-1:0] value;
		logic                      start_req;
	} item_t;

	typedef struct packed {
		logic [LEN_OUT_W-1:0] lis_length;
		logic                 overflow;
	} res_t;

endpackage

`default_nettype wire

// ----- sv/lis_tails_ram.sv -----
// Tail store: single-port-write, single-port-read synchronous memory.
// Read data is registered. No package dependency.
`default_nettype none

module lis_tails_ram #(
	parameter int unsigned DEPTH = 1024,
	parameter int unsigned WIDTH = 32,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic [AW-1:0]    wr_addr,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic             rd_en,
	input  wire logic [AW-1:0]    rd_addr,
	output logic      [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

// ----- sv/lis_ctrl.sv -----
// Sequencer for the tail store: last-tail check, binary search, write-back
// and the result register. Uses lis_pkg; drives lis_tails_ram.
`default_nettype none

module lis_ctrl #(
	parameter int unsigned MAX_LEN = 1024,
	localparam int unsigned AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1,
	localparam int unsigned LW = $clog2(MAX_LEN + 1)
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           item_valid,
	output logic                item_ready,
	input  wire lis_pkg::item_t item,
	output logic                res_valid,
	input  wire logic           res_ready,
	output lis_pkg::res_t       res,
	output logic                wr_en,
	output logic [AW-1:0]       wr_addr,
	output logic [31:0]         wr_data,
	output logic                rd_en,
	output logic [AW-1:0]       rd_addr,
	input  wire logic [31:0]    rd_data
);

	import lis_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LAST,
		ST_SRCH,
		ST_OUT
	} state_t;

	state_t               state_q;
	logic [VALUE_W-1:0]   key_q;
	logic [LW-1:0]        len_q;
	logic                 ovf_q;
	logic [AW-1:0]        lo_q;
	logic [AW-1:0]        hi_q;
	logic [AW-1:0]        mid_q;
	logic                 res_valid_q;
	res_t                 res_q;

	logic [VALUE_W-1:0]   key_in;
	logic [LW-1:0]        len_m1;
	logic                 first_item;
	logic                 is_full;
	logic                 above_last;
	logic [AW-1:0]        nlo;
	logic [AW-1:0]        nhi;
	logic [AW-1:0]        nmid;
	logic                 more;
	logic [LW+LEN_OUT_W-1:0] len_wide;

	assign key_in     = VALUE_W'(item.value) ^ SIGN_BIAS;
	assign len_m1     = len_q - LW'(1);
	assign first_item = item.start_req || (len_q == '0);
	assign is_full    = (len_q == LW'(MAX_LEN));
	assign above_last = key_q > rd_data;
	assign nmid       = nlo + ((nhi - nlo) >> 1);
	assign more       = nlo < nhi;
	assign len_wide   = {{LEN_OUT_W{1'b0}}, len_q};

	assign item_ready = (state_q == ST_IDLE);
	assign res_valid  = res_valid_q;
	assign res        = res_q;

	always_comb begin
		nlo = '0;
		nhi = len_m1[AW-1:0];
		if (state_q == ST_SRCH) begin
			nlo = lo_q;
			nhi = hi_q;
			if (rd_data < key_q) begin
				nlo = mid_q + AW'(1);
			end else begin
				nhi = mid_q;
			end
		end
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = '0;
		wr_data = key_q;
		rd_en   = 1'b0;
		rd_addr = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (item_valid) begin
					if (first_item) begin
						wr_en   = 1'b1;
						wr_data = key_in;
					end else begin
						rd_en   = 1'b1;
						rd_addr = len_m1[AW-1:0];
					end
				end
			end
			ST_LAST, ST_SRCH: begin
				if (state_q == ST_LAST && above_last) begin
					wr_en   = !is_full;
					wr_addr = len_q[AW-1:0];
				end else if (more) begin
					rd_en   = 1'b1;
					rd_addr = nmid;
				end else begin
					wr_en   = 1'b1;
					wr_addr = nlo;
				end
			end
			ST_OUT: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			key_q       <= '0;
			len_q       <= '0;
			ovf_q       <= 1'b0;
			lo_q        <= '0;
			hi_q        <= '0;
			mid_q       <= '0;
			res_valid_q <= 1'b0;
			res_q       <= '0;
		end else begin
			if (res_valid_q && res_ready && state_q != ST_OUT) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (item_valid) begin
						key_q <= key_in;
						if (item.start_req) begin
							ovf_q <= 1'b0;
						end
						if (first_item) begin
							len_q   <= LW'(1);
							state_q <= ST_OUT;
						end else begin
							state_q <= ST_LAST;
						end
					end
				end
				ST_LAST, ST_SRCH: begin
					if (state_q == ST_LAST && above_last) begin
						if (is_full) begin
							ovf_q <= 1'b1;
						end else begin
							len_q <= len_q + LW'(1);
						end
						state_q <= ST_OUT;
					end else if (more) begin
						lo_q    <= nlo;
						hi_q    <= nhi;
						mid_q   <= nmid;
						state_q <= ST_SRCH;
					end else begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (!res_valid_q || res_ready) begin
						res_q.lis_length <= len_wide[LEN_OUT_W-1:0];
						res_q.overflow   <= ovf_q;
						res_valid_q      <= 1'b1;
						state_q          <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_srch_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SRCH) |-> $past(rd_en))
		else $error("search step without a preceding read");

	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= LW'(MAX_LEN))
		else $error("length beyond store depth");

	a_wr_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (LW'(wr_addr) <= len_q))
		else $error("tail write past the end of the sequence");

	a_search_window: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SRCH) |-> (lo_q <= mid_q && mid_q < hi_q))
		else $error("search window broken");

	a_out_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT) |-> (len_q != '0))
		else $error("result with empty sequence");

endmodule

`default_nettype wire

// ----- sv/lis_tails_binary_search.sv -----
// Longest strictly increasing subsequence tracker (tails method), top level.
// Depends on lis_pkg, lis_ctrl and lis_tails_ram.
//
// Usage: signed values arrive as beats on the item channel (valid/ready);
// each beat yields exactly one beat on the res channel carrying the current
// subsequence length and the sticky overflow flag. A beat with start_req
// set clears length and overflow before the value is handled.
//
// Sequence: an item that starts a sequence (or follows reset) goes from
// ST_IDLE to ST_OUT, which loads the result register. For any other item
// the last tail is read in ST_IDLE and compared in ST_LAST, then come k
// binary-search reads of the tail memory, each checked in ST_SRCH, k in
// 0..ceil(log2(MAX_LEN)) (at most 10 for 1024 entries), then ST_OUT. The
// single read port of the tail memory takes one read per cycle, with
// registered data; one item is in flight at a time, so the next beat is taken once the result is loaded.
//
// Reset clears length, overflow and the control state; tail contents are
// never read before they are written, so the memory needs no clearing.
// If the receiver stalls, the result waits in the output register; the
// next item is still taken and processed, and holds in its final state
// until the register frees.
`default_nettype none

module lis_tails_binary_search #(
	parameter int unsigned MAX_LEN = 1024
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           item_valid,
	output logic                item_ready,
	input  wire lis_pkg::item_t item,
	output logic                res_valid,
	input  wire logic           res_ready,
	output lis_pkg::res_t       res
);

	import lis_pkg::*;

	localparam int unsigned AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

	logic               wr_en;
	logic [AW-1:0]      wr_addr;
	logic [VALUE_W-1:0] wr_data;
	logic               rd_en;
	logic [AW-1:0]      rd_addr;
	logic [VALUE_W-1:0] rd_data;

	lis_ctrl #(
		.MAX_LEN(MAX_LEN)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res        (res),
		.wr_en      (wr_en),
		.wr_addr    (wr_addr),
		.wr_data    (wr_data),
		.rd_en      (rd_en),
		.rd_addr    (rd_addr),
		.rd_data    (rd_data)
	);

	lis_tails_ram #(
		.DEPTH(MAX_LEN),
		.WIDTH(VALUE_W)
	) u_tails (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

endmodule

`default_nettype wire
